### rtl/clnf_pkg.sv
// Types and constants shared by the character-LCD number formatter.
// No dependencies; imported by the controller, the datapath and the top level.
package clnf_pkg;

   localparam logic [2:0] OP_CHAR = 3'd0;
   localparam logic [2:0] OP_UDEC = 3'd1;
   localparam logic [2:0] OP_SDEC = 3'd2;
   localparam logic [2:0] OP_HEX  = 3'd3;
   localparam logic [2:0] OP_BIN  = 3'd4;

   localparam logic [1:0] LINE_ONE = 2'd1;
   localparam logic [1:0] LINE_TWO = 2'd2;

   localparam logic [7:0] CMD_SET_ADDR = 8'h80;
   localparam logic [7:0] LINE_TWO_OFS = 8'h40;
   localparam logic [7:0] CHR_ZERO     = 8'h30;
   localparam logic [7:0] CHR_A        = 8'h41;
   localparam logic [7:0] CHR_PLUS     = 8'h2B;
   localparam logic [7:0] CHR_MINUS    = 8'h2D;

   localparam logic [4:0] LIMIT_DEC = 5'd5;
   localparam logic [4:0] LIMIT_HEX = 5'd4;
   localparam logic [4:0] LIMIT_BIN = 5'd16;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_CONVERT,
      ST_CURSOR,
      ST_SIGN,
      ST_BODY
   } state_type;

   typedef enum logic [1:0] {
      SEL_CURSOR,
      SEL_SIGN,
      SEL_BODY
   } sel_type;

   typedef struct packed {
      logic    accept;
      logic    conv_step;
      logic    emit;
      sel_type sel;
   } ctl_cmd_type;

   typedef struct packed {
      logic op_valid;
      logic is_dec;
      logic has_cursor;
      logic has_sign;
      logic body_empty;
      logic body_last;
      logic conv_done;
      logic out_free;
   } ctl_status_type;

endpackage

### rtl/clnf_ctrl.sv
// Sequencing state machine of the character-LCD number formatter.
// Depends on clnf_pkg; drives the datapath through a command struct.
module clnf_ctrl import clnf_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  ctl_status_type status,
   output ctl_cmd_type    cmd
);

   state_type state_ff, state_in;
   state_type after_cursor, after_sign;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      after_sign   = status.body_empty ? ST_IDLE : ST_BODY;
      after_cursor = status.has_sign ? ST_SIGN : after_sign;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            if (!status.op_valid) begin
               state_in = ST_IDLE;
            end else if (status.is_dec) begin
               state_in = ST_CONVERT;
            end else begin
               state_in = status.has_cursor ? ST_CURSOR : after_cursor;
            end
         end
         ST_CONVERT: begin
            if (status.conv_done) begin
               state_in = status.has_cursor ? ST_CURSOR : after_cursor;
            end
         end
         ST_CURSOR: begin
            if (status.out_free) begin
               state_in = after_cursor;
            end
         end
         ST_SIGN: begin
            if (status.out_free) begin
               state_in = after_sign;
            end
         end
         ST_BODY: begin
            if (status.out_free && status.body_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall     = 1'b1;
      cmd.accept    = 1'b0;
      cmd.conv_step = 1'b0;
      cmd.emit      = 1'b0;
      cmd.sel       = SEL_BODY;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         ST_SETUP: begin
         end
         ST_CONVERT: begin
            cmd.conv_step = 1'b1;
         end
         ST_CURSOR: begin
            cmd.emit = status.out_free;
            cmd.sel  = SEL_CURSOR;
         end
         ST_SIGN: begin
            cmd.emit = status.out_free;
            cmd.sel  = SEL_SIGN;
         end
         ST_BODY: begin
            cmd.emit = status.out_free;
            cmd.sel  = SEL_BODY;
         end
         default: begin
         end
      endcase
   end

endmodule

### rtl/clnf_datapath.sv
// Datapath of the character-LCD number formatter: request registers, binary to
// BCD converter, digit selection and the output word register. Uses clnf_pkg.
module clnf_datapath import clnf_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  ctl_cmd_type    cmd,
   output ctl_status_type status,
   input  logic [2:0]     req_op,
   input  logic [1:0]     req_line,
   input  logic [4:0]     req_column,
   input  logic [15:0]    req_value,
   input  logic [4:0]     req_digit_count,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output logic           rsp_reg_select,
   output logic [7:0]     rsp_bus_byte,
   output logic           rsp_last
);

   function automatic logic [7:0] digit_char(input logic [3:0] d);
      logic [7:0] c;
      if (d < 4'd10) begin
         c = CHR_ZERO + {4'd0, d};
      end else begin
         c = CHR_A + {4'd0, d} - 8'd10;
      end
      return c;
   endfunction

   logic [2:0]  op_ff;
   logic [1:0]  line_ff;
   logic [4:0]  column_ff;
   logic [15:0] mag_ff, mag_in;
   logic        neg_ff, neg_in;
   logic [4:0]  rem_ff, rem_in;
   logic [19:0] bcd_ff, bcd_in;
   logic [15:0] sh_ff, sh_in;
   logic [3:0]  conv_cnt_ff;
   logic        rsp_valid_ff;
   logic        rsp_rs_ff, rsp_rs_in;
   logic [7:0]  rsp_byte_ff, rsp_byte_in;
   logic        rsp_last_ff, rsp_last_in;

   logic [4:0]  limit;
   logic [19:0] bcd_adj;
   logic [4:0]  pos_w;
   logic [3:0]  pos;
   logic [3:0]  digit;
   logic [7:0]  cursor_byte;

   always_comb begin
      case (req_op) inside
         OP_UDEC, OP_SDEC: limit = LIMIT_DEC;
         OP_HEX:           limit = LIMIT_HEX;
         OP_BIN:           limit = LIMIT_BIN;
         default:          limit = 5'd0;
      endcase
      neg_in = (req_op == OP_SDEC) && req_value[15];
      mag_in = neg_in ? 16'(~req_value + 16'd1) : req_value;
      if (req_op == OP_CHAR) begin
         rem_in = 5'd1;
      end else begin
         rem_in = (req_digit_count > limit) ? limit : req_digit_count;
      end
   end

   always_comb begin
      for (int n = 0; n < 5; n++) begin
         bcd_adj[4*n +: 4] = (bcd_ff[4*n +: 4] >= 4'd5) ?
                             4'(bcd_ff[4*n +: 4] + 4'd3) : bcd_ff[4*n +: 4];
      end
      bcd_in = {bcd_adj[18:0], sh_ff[15]};
      sh_in  = {sh_ff[14:0], 1'b0};
   end

   always_comb begin
      pos_w = rem_ff - 5'd1;
      pos   = pos_w[3:0];
      case (op_ff)
         OP_HEX:           digit = 4'(mag_ff >> {pos[1:0], 2'b00});
         OP_BIN:           digit = {3'd0, mag_ff[pos]};
         default:          digit = 4'(bcd_ff >> {pos[2:0], 2'b00});
      endcase
      cursor_byte = CMD_SET_ADDR | ({3'd0, column_ff} - 8'd1 +
                    ((line_ff == LINE_TWO) ? LINE_TWO_OFS : 8'd0));
      rsp_rs_in   = 1'b1;
      rsp_byte_in = 8'd0;
      rsp_last_in = 1'b0;
      case (cmd.sel)
         SEL_CURSOR: begin
            rsp_rs_in   = 1'b0;
            rsp_byte_in = cursor_byte;
            rsp_last_in = status.body_empty && !status.has_sign;
         end
         SEL_SIGN: begin
            rsp_byte_in = neg_ff ? CHR_MINUS : CHR_PLUS;
            rsp_last_in = status.body_empty;
         end
         default: begin
            rsp_byte_in = (op_ff == OP_CHAR) ? mag_ff[7:0] : digit_char(digit);
            rsp_last_in = status.body_last;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff     <= req_op;
         line_ff   <= req_line;
         column_ff <= req_column;
         mag_ff    <= mag_in;
         neg_ff    <= neg_in;
         sh_ff     <= mag_in;
         bcd_ff    <= '0;
      end else if (cmd.conv_step) begin
         sh_ff     <= sh_in;
         bcd_ff    <= bcd_in;
      end
      if (cmd.emit) begin
         rsp_rs_ff   <= rsp_rs_in;
         rsp_byte_ff <= rsp_byte_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff       <= '0;
         conv_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.accept) begin
            rem_ff      <= rem_in;
            conv_cnt_ff <= '0;
         end else begin
            if (cmd.conv_step) begin
               conv_cnt_ff <= conv_cnt_ff + 4'd1;
            end
            if (cmd.emit && cmd.sel == SEL_BODY) begin
               rem_ff <= rem_ff - 5'd1;
            end
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      status.op_valid   = (op_ff == OP_CHAR) || (op_ff == OP_UDEC) ||
                          (op_ff == OP_SDEC) || (op_ff == OP_HEX) || (op_ff == OP_BIN);
      status.is_dec     = (op_ff == OP_UDEC) || (op_ff == OP_SDEC);
      status.has_cursor = (line_ff == LINE_ONE) || (line_ff == LINE_TWO);
      status.has_sign   = (op_ff == OP_SDEC);
      status.body_empty = (rem_ff == 5'd0);
      status.body_last  = (rem_ff == 5'd1);
      status.conv_done  = (conv_cnt_ff == 4'hF);
      status.out_free   = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_reg_select = rsp_rs_ff;
   assign rsp_bus_byte   = rsp_byte_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

### rtl/char_lcd_number_formatter.sv
// Character-LCD number formatter, top level.
// Depends on clnf_pkg, clnf_ctrl and clnf_datapath.
//
// A request word on the req_ channel (op, line, column, value, digit_count)
// becomes a run of LCD bus words on the rsp_ channel: an optional cursor
// command (reg_select 0), an optional sign, then the character or the digits,
// most significant first. rsp_last marks the final word of a run; a request
// with an unknown op, or with no cursor, no sign and no digits, gives no word.
// Both channels use valid/stall; a word moves when valid is high and stall low.
// One request is handled at a time: req_stall is high from the accept until
// the last word of the run has entered the output register.
// After accept the sequencer passes a setup state, then binary-to-BCD
// conversion (one bit a cycle) for decimal ops only, then loads one word a
// cycle into the output register while the receiver does not stall. When
// the receiver stalls, the output register holds its word and the
// sequencer waits. Synchronous reset returns the controller to idle and
// empties the output register.
module char_lcd_number_formatter import clnf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_op,
   input  logic [1:0]  req_line,
   input  logic [4:0]  req_column,
   input  logic [15:0] req_value,
   input  logic [4:0]  req_digit_count,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_reg_select,
   output logic [7:0]  rsp_bus_byte,
   output logic        rsp_last
);

   ctl_cmd_type    cmd;
   ctl_status_type status;

   clnf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   clnf_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_op          (req_op),
      .req_line        (req_line),
      .req_column      (req_column),
      .req_value       (req_value),
      .req_digit_count (req_digit_count),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_reg_select  (rsp_reg_select),
      .rsp_bus_byte    (rsp_bus_byte),
      .rsp_last        (rsp_last)
   );

   a_emit_room: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("word loaded while output register still held");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while previous one in flight");

   a_body_count: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && cmd.sel == SEL_BODY) |-> !status.body_empty)
      else $error("digit emitted with no digits left");

   a_convert_dec: assert property (@(posedge clock) disable iff (reset)
      cmd.conv_step |-> status.is_dec)
      else $error("BCD conversion for non-decimal request");

endmodule

### tb/tb.sv
// Self-checking testbench for char_lcd_number_formatter: a directed table,
// then random requests under several idle/stall mixes, checked word by word.
// Depends on clnf_pkg and the char_lcd_number_formatter RTL.
module tb;
   import clnf_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] OP_BAD_LO = 3'd5;
   localparam logic [2:0] OP_BAD_MID = 3'd6;
   localparam logic [2:0] OP_BAD_HI = 3'd7;
   localparam logic [1:0] LINE_NONE = 2'd0;
   localparam logic [1:0] LINE_THREE = 2'd3;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_LIMIT = 20000;
   localparam int TAIL_CYCLES = 40;
   localparam int ITEMS_PER_PHASE = 33;
   localparam int USE_PREDICTOR = -1;

   typedef struct packed {
      logic [2:0]  op;
      logic [1:0]  line;
      logic [4:0]  column;
      logic [15:0] value;
      logic [4:0]  digit_count;
   } lcd_request_type;

   typedef struct packed {
      logic       reg_select;
      logic [7:0] bus_byte;
      logic       last;
   } lcd_word_type;

   typedef struct packed {
      lcd_request_type    req;
      int                 n_typed;
      lcd_word_type [1:0] typed;
   } stimulus_row_type;

   localparam lcd_word_type NO_WORD = '0;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_op = '0;
   logic [1:0]  req_line = '0;
   logic [4:0]  req_column = '0;
   logic [15:0] req_value = '0;
   logic [4:0]  req_digit_count = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_reg_select;
   logic [7:0]  rsp_bus_byte;
   logic        rsp_last;

   lcd_word_type     expected_lcd_words[$];
   stimulus_row_type stimulus_rows[$];
   lcd_word_type     due_word;
   int               mismatches = 0;
   int               requests_sent = 0;
   int               words_checked = 0;
   int               idle_pct = 0;
   int               stall_pct = 0;
   int               hold_left = 0;
   logic             hold_request = 1'b0;

   char_lcd_number_formatter i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_line        (req_line),
      .req_column      (req_column),
      .req_value       (req_value),
      .req_digit_count (req_digit_count),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_reg_select  (rsp_reg_select),
      .rsp_bus_byte    (rsp_bus_byte),
      .rsp_last        (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic lcd_word_type lw(input logic rs, input logic [7:0] b, input logic lst);
      lcd_word_type w;
      w.reg_select = rs;
      w.bus_byte = b;
      w.last = lst;
      return w;
   endfunction

   function automatic void add_row(input logic [2:0] op, input logic [1:0] line,
                                   input logic [4:0] column, input logic [15:0] value,
                                   input logic [4:0] digit_count, input int n_typed,
                                   input lcd_word_type w0, input lcd_word_type w1);
      stimulus_row_type row;
      row.req.op = op;
      row.req.line = line;
      row.req.column = column;
      row.req.value = value;
      row.req.digit_count = digit_count;
      row.n_typed = n_typed;
      row.typed[0] = w0;
      row.typed[1] = w1;
      stimulus_rows.push_back(row);
   endfunction

   function automatic void predict_lcd_words(input lcd_request_type r);
      lcd_word_type run[$];
      logic [7:0]   addr;
      logic [15:0]  mag;
      logic [4:0]   lim;
      logic [4:0]   cnt;
      int           base;
      int           div;
      int           digit;
      if (r.op > OP_BIN) return;
      addr = 8'(r.column) - 8'd1;
      if (r.line == LINE_ONE) begin
         run.push_back(lw(1'b0, CMD_SET_ADDR | addr, 1'b0));
      end else if (r.line == LINE_TWO) begin
         run.push_back(lw(1'b0, CMD_SET_ADDR | (addr + LINE_TWO_OFS), 1'b0));
      end
      if (r.op == OP_CHAR) begin
         run.push_back(lw(1'b1, r.value[7:0], 1'b0));
      end else begin
         mag = r.value;
         if (r.op == OP_SDEC) begin
            if (r.value[15]) begin
               run.push_back(lw(1'b1, CHR_MINUS, 1'b0));
               mag = 16'd0 - r.value;
            end else begin
               run.push_back(lw(1'b1, CHR_PLUS, 1'b0));
            end
         end
         if (r.op == OP_HEX) begin
            base = 16;
            lim = LIMIT_HEX;
         end else if (r.op == OP_BIN) begin
            base = 2;
            lim = LIMIT_BIN;
         end else begin
            base = 10;
            lim = LIMIT_DEC;
         end
         cnt = (r.digit_count > lim) ? lim : r.digit_count;
         for (int i = int'(cnt); i > 0; i--) begin
            div = base ** (i - 1);
            digit = (int'(mag) / div) % base;
            run.push_back(lw(1'b1, (digit < 10) ? 8'(int'(CHR_ZERO) + digit)
                                                : 8'(int'(CHR_A) + digit - 10), 1'b0));
         end
      end
      if (run.size() > 0) run[run.size() - 1].last = 1'b1;
      foreach (run[i]) expected_lcd_words.push_back(run[i]);
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch at %0t ns: %s got %0h want %0h", $time, what, got, want);
      mismatches++;
   endtask

   task automatic offer_request(input lcd_request_type r, input int n_typed,
                                input lcd_word_type [1:0] typed);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= r.op;
      req_line <= r.line;
      req_column <= r.column;
      req_value <= r.value;
      req_digit_count <= r.digit_count;
      do @(posedge clock); while (req_stall);
      if (n_typed == USE_PREDICTOR) begin
         predict_lcd_words(r);
      end else begin
         for (int i = 0; i < n_typed; i++) expected_lcd_words.push_back(typed[i]);
      end
      requests_sent++;
   endtask

   task automatic drain_words();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (expected_lcd_words.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
   endtask

   function automatic lcd_request_type random_request();
      lcd_request_type r;
      r.op = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      r.line = 2'($urandom);
      r.column = ($urandom_range(0, 4) == 0) ? 5'($urandom) : 5'($urandom_range(1, 16));
      r.value = 16'($urandom);
      r.digit_count = ($urandom_range(0, 1) == 0) ? 5'($urandom) : 5'($urandom_range(0, 5));
      return r;
   endfunction

   // receiver: random stall, or a long counted hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_lcd_words.size() == 0) begin
            report_mismatch("unexpected word", {rsp_reg_select, rsp_bus_byte, rsp_last}, 0);
         end else begin
            due_word = expected_lcd_words.pop_front();
            if (rsp_reg_select !== due_word.reg_select)
               report_mismatch("reg_select", rsp_reg_select, due_word.reg_select);
            if (rsp_bus_byte !== due_word.bus_byte)
               report_mismatch("bus_byte", rsp_bus_byte, due_word.bus_byte);
            if (rsp_last !== due_word.last)
               report_mismatch("last", rsp_last, due_word.last);
         end
         words_checked++;
      end
   end

   initial begin
      int              counted;
      lcd_request_type r;
      int              n_directed;

      add_row(OP_CHAR, LINE_ONE, 5'd1, 16'h0041, 5'd0, 2,
              lw(1'b0, CMD_SET_ADDR, 1'b0), lw(1'b1, 8'h41, 1'b1));
      add_row(OP_CHAR, LINE_TWO, 5'd16, 16'hFF5A, 5'd31, 2,
              lw(1'b0, 8'hCF, 1'b0), lw(1'b1, 8'h5A, 1'b1));
      add_row(OP_CHAR, LINE_NONE, 5'd1, 16'h0000, 5'd0, 1, lw(1'b1, 8'h00, 1'b1), NO_WORD);
      add_row(OP_CHAR, LINE_THREE, 5'd16, 16'h00FF, 5'd5, 1, lw(1'b1, 8'hFF, 1'b1), NO_WORD);
      add_row(OP_BAD_LO, LINE_ONE, 5'd1, 16'hFFFF, 5'd5, 0, NO_WORD, NO_WORD);
      add_row(OP_BAD_MID, LINE_TWO, 5'd16, 16'h1234, 5'd16, 0, NO_WORD, NO_WORD);
      add_row(OP_BAD_HI, LINE_ONE, 5'd31, 16'h8000, 5'd31, 0, NO_WORD, NO_WORD);
      add_row(OP_UDEC, LINE_ONE, 5'd1, 16'hFFFF, 5'd5, USE_PREDICTOR, NO_WORD, NO_WORD);
      add_row(OP_UDEC, LINE_TWO, 5'd16, 16'd12345, 5'd31, USE_PREDICTOR, NO_WORD, NO_WORD);
      add_row(OP_UDEC, LINE_NONE, 5'd5, 16'd0, 5'd0, 0, NO_WORD, NO_WORD);
      add_row(OP_UDEC, LINE_THREE, 5'd5, 16'd0, 5'd5, USE_PREDICTOR, NO_WORD, NO_WORD);
      add_row(OP_SDEC, LINE_TWO, 5'd1, 16'h8000, 5'd5, USE_PREDICTOR, NO_WORD, NO_WORD);
      add_row(OP_SDEC, LINE_ONE, 5'd16, 16'h7FFF, 5'd16, USE_PREDICTOR, NO_WORD, NO_WORD);
      add_row(OP_SDEC, LINE_NONE, 5'd1, 16'hFFFF, 5'd0, 1, lw(1'b1, CHR_MINUS, 1'b1), NO_WORD);
      add_row(OP_SDEC, LINE_THREE, 5'd1, 16'h0000, 5'd1, 2,
              lw(1'b1, CHR_PLUS, 1'b0), lw(1'b1, CHR_ZERO, 1'b1));
      add_row(OP_HEX, LINE_ONE, 5'd16, 16'hABCD, 5'd4, USE_PREDICTOR, NO_WORD, NO_WORD);
      add_row(OP_HEX, LINE_NONE, 5'd1, 16'hFFFF, 5'd31, USE_PREDICTOR, NO_WORD, NO_WORD);
      add_row(OP_HEX, LINE_NONE, 5'd1, 16'h0000, 5'd1, 1, lw(1'b1, CHR_ZERO, 1'b1), NO_WORD);
      add_row(OP_BIN, LINE_TWO, 5'd8, 16'hA5A5, 5'd16, USE_PREDICTOR, NO_WORD, NO_WORD);
      add_row(OP_BIN, LINE_NONE, 5'd1, 16'h5A5A, 5'd31, USE_PREDICTOR, NO_WORD, NO_WORD);
      add_row(OP_BIN, LINE_ONE, 5'd9, 16'hFFFF, 5'd0, 1, lw(1'b0, 8'h88, 1'b1), NO_WORD);
      add_row(OP_CHAR, LINE_ONE, 5'd0, 16'h0030, 5'd0, 2,
              lw(1'b0, 8'hFF, 1'b0), lw(1'b1, 8'h30, 1'b1));
      add_row(OP_CHAR, LINE_TWO, 5'd0, 16'h007E, 5'd0, 2,
              lw(1'b0, 8'hBF, 1'b0), lw(1'b1, 8'h7E, 1'b1));
      add_row(OP_HEX, LINE_ONE, 5'd31, 16'h1234, 5'd2, USE_PREDICTOR, NO_WORD, NO_WORD);
      add_row(OP_UDEC, LINE_TWO, 5'd31, 16'd9, 5'd1, USE_PREDICTOR, NO_WORD, NO_WORD);

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (stimulus_rows[i])
         offer_request(stimulus_rows[i].req, stimulus_rows[i].n_typed, stimulus_rows[i].typed);
      n_directed = requests_sent;
      drain_words();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               idle_pct = 0;
               stall_pct = 0;
               hold_request = 1'b1;
            end
            1: begin
               idle_pct = 74;
               stall_pct = 0;
            end
            2: begin
               idle_pct = 0;
               stall_pct = 74;
            end
            default: begin
               idle_pct = 9;
               stall_pct = 9;
            end
         endcase
         counted = 0;
         while (counted < ITEMS_PER_PHASE) begin
            r = random_request();
            offer_request(r, USE_PREDICTOR, '0);
            if (r.op <= OP_BIN) counted++;
         end
         drain_words();
      end

      stall_pct = 0;
      repeat (TAIL_CYCLES) @(posedge clock);
      foreach (expected_lcd_words[i])
         report_mismatch("missing word", 0, expected_lcd_words[i]);

      $display("covered %0d requests (%0d from the table), %0d bus words checked",
               requests_sent, n_directed, words_checked);
      $display("mixes: free flow with long receiver hold, sender idle, receiver stall, both");
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
